// File: sv/rtif_pkg.sv
package rtif_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRACTION_BITS = 16;
   localparam int TRI_WIDTH = 22;
   localparam int IDX_WIDTH = 24;
   localparam int UV_WIDTH = FRACTION_BITS + 1;
   localparam int PROD_WIDTH = 2 * COORD_WIDTH;
   localparam int DOT_WIDTH = PROD_WIDTH + 3;
   localparam int QUO_WIDTH = COORD_WIDTH - 1;
   localparam int QCNT_WIDTH = $clog2(QUO_WIDTH + 1);
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = COORD_WIDTH;
   localparam int MAC_STEPS = 24;
   localparam int STEP_WIDTH = 5;
   // Quotient exceeds the coordinate maximum when ts >= a << TSAT_SHIFT.
   localparam int TSAT_SHIFT = COORD_WIDTH - 1 - FRACTION_BITS;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_ONE = COORD_WIDTH'(1) <<< FRACTION_BITS;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIR_Z = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIDDEN_FIRST = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIDDEN_LAST = 3'd7;

   typedef struct packed {
      logic                           first_of_ray;
      logic [TRI_WIDTH-1:0]           triangle_index;
      logic signed [COORD_WIDTH-1:0]  a_x;
      logic signed [COORD_WIDTH-1:0]  a_y;
      logic signed [COORD_WIDTH-1:0]  a_z;
      logic signed [COORD_WIDTH-1:0]  b_x;
      logic signed [COORD_WIDTH-1:0]  b_y;
      logic signed [COORD_WIDTH-1:0]  b_z;
      logic signed [COORD_WIDTH-1:0]  c_x;
      logic signed [COORD_WIDTH-1:0]  c_y;
      logic signed [COORD_WIDTH-1:0]  c_z;
   } req_word_type;

   typedef struct packed {
      logic                           skipped;
      logic                           closer_hit;
      logic                           any_hit;
      logic signed [COORD_WIDTH-1:0]  best_distance;
      logic [UV_WIDTH-1:0]            best_u;
      logic [UV_WIDTH-1:0]            best_v;
      logic [TRI_WIDTH-1:0]           best_triangle;
   } rsp_word_type;

   typedef enum logic [4:0] {
      OPND_E1X, OPND_E1Y, OPND_E1Z,
      OPND_E2X, OPND_E2Y, OPND_E2Z,
      OPND_SX, OPND_SY, OPND_SZ,
      OPND_DX, OPND_DY, OPND_DZ,
      OPND_HX, OPND_HY, OPND_HZ,
      OPND_QX, OPND_QY, OPND_QZ
   } opnd_type;

   typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_HX, DST_HY, DST_HZ, DST_QX, DST_QY, DST_QZ,
      DST_DOT_A, DST_DOT_U, DST_DOT_V, DST_DOT_T
   } dest_type;

   typedef struct packed {
      opnd_type   sel_a;
      opnd_type   sel_b;
      acc_op_type op;
      dest_type   dest;
   } mac_step_type;

   typedef struct packed {
      logic       mul_en;
      logic       acc_en;
      acc_op_type op;
   } mac_ctrl_type;

   typedef struct packed {
      logic                  start;
      logic [QCNT_WIDTH-1:0] bits;
      logic [DOT_WIDTH-1:0]  rem_init;
      logic [QUO_WIDTH-1:0]  low_init;
   } div_ctrl_type;

   // Sequence of products: the two cross products, then the four dot products.
   function automatic mac_step_type mac_step(input logic [STEP_WIDTH-1:0] step);
      mac_step_type r;
      r = '{OPND_E1X, OPND_E1X, ACC_LOAD, DST_NONE};
      case (step)
         5'd0:  r = '{OPND_DY, OPND_E2Z, ACC_LOAD, DST_NONE};
         5'd1:  r = '{OPND_DZ, OPND_E2Y, ACC_SUB, DST_HX};
         5'd2:  r = '{OPND_DZ, OPND_E2X, ACC_LOAD, DST_NONE};
         5'd3:  r = '{OPND_DX, OPND_E2Z, ACC_SUB, DST_HY};
         5'd4:  r = '{OPND_DX, OPND_E2Y, ACC_LOAD, DST_NONE};
         5'd5:  r = '{OPND_DY, OPND_E2X, ACC_SUB, DST_HZ};
         5'd6:  r = '{OPND_SY, OPND_E1Z, ACC_LOAD, DST_NONE};
         5'd7:  r = '{OPND_SZ, OPND_E1Y, ACC_SUB, DST_QX};
         5'd8:  r = '{OPND_SZ, OPND_E1X, ACC_LOAD, DST_NONE};
         5'd9:  r = '{OPND_SX, OPND_E1Z, ACC_SUB, DST_QY};
         5'd10: r = '{OPND_SX, OPND_E1Y, ACC_LOAD, DST_NONE};
         5'd11: r = '{OPND_SY, OPND_E1X, ACC_SUB, DST_QZ};
         5'd12: r = '{OPND_E1X, OPND_HX, ACC_LOAD, DST_NONE};
         5'd13: r = '{OPND_E1Y, OPND_HY, ACC_ADD, DST_NONE};
         5'd14: r = '{OPND_E1Z, OPND_HZ, ACC_ADD, DST_DOT_A};
         5'd15: r = '{OPND_SX, OPND_HX, ACC_LOAD, DST_NONE};
         5'd16: r = '{OPND_SY, OPND_HY, ACC_ADD, DST_NONE};
         5'd17: r = '{OPND_SZ, OPND_HZ, ACC_ADD, DST_DOT_U};
         5'd18: r = '{OPND_DX, OPND_QX, ACC_LOAD, DST_NONE};
         5'd19: r = '{OPND_DY, OPND_QY, ACC_ADD, DST_NONE};
         5'd20: r = '{OPND_DZ, OPND_QZ, ACC_ADD, DST_DOT_V};
         5'd21: r = '{OPND_E2X, OPND_QX, ACC_LOAD, DST_NONE};
         5'd22: r = '{OPND_E2Y, OPND_QY, ACC_ADD, DST_NONE};
         5'd23: r = '{OPND_E2Z, OPND_QZ, ACC_ADD, DST_DOT_T};
         default: r = '{OPND_E1X, OPND_E1X, ACC_LOAD, DST_NONE};
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_diff(
      input logic signed [COORD_WIDTH-1:0] x,
      input logic signed [COORD_WIDTH-1:0] y);
      logic signed [COORD_WIDTH:0] d;
      d = {x[COORD_WIDTH-1], x} - {y[COORD_WIDTH-1], y};
      if (d[COORD_WIDTH] != d[COORD_WIDTH-1]) begin
         return d[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
      end
      return d[COORD_WIDTH-1:0];
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_cross(
      input logic signed [DOT_WIDTH-1:0] acc);
      logic signed [DOT_WIDTH-1:0] sh;
      logic signed [DOT_WIDTH-1:0] hi_lim;
      logic signed [DOT_WIDTH-1:0] lo_lim;
      sh = acc >>> FRACTION_BITS;
      hi_lim = DOT_WIDTH'(COORD_MAX);
      lo_lim = DOT_WIDTH'(COORD_MIN);
      if (sh > hi_lim) begin
         return COORD_MAX;
      end
      if (sh < lo_lim) begin
         return COORD_MIN;
      end
      return sh[COORD_WIDTH-1:0];
   endfunction

endpackage

// File: sv/ray_triangle_intersect_filtered.sv
// Ray against triangle test with a hidden vertex-index range, keeping the
// closest hit of the current ray.
// Input channel req_*: one word per triangle (its vertices and index p). A word
// with first_of_ray set clears the stored hit before the test. Result channel
// rsp_*: exactly one word per triangle, showing the stored closest hit after it.
// Both channels move a word when valid is high and stall is low.
// Configuration csr_*: ray origin, direction and hidden range, written with
// csr_write_en while no triangle is in flight.
// One triangle is worked on at a time. A skipped triangle goes from acceptance
// straight to the done state. A tested one runs 24 products and sums through one
// shared multiplier and accumulator, then sign handling and range checks (the
// check and test states), then up to three quotients from one bit-serial
// divider (t of 31 bits, then u and v of 17 bits each).
// The next triangle is accepted once the result sits in the output register,
// even while rsp_stall holds that result back; completion waits on a stall.
// A synchronous reset loads the register defaults (direction 0,0,1.0, empty
// hidden range) and clears the stored hit to the maximum distance.
module ray_triangle_intersect_filtered (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  rtif_pkg::req_word_type                   req_word,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output rtif_pkg::rsp_word_type                   rsp_word,
   input  logic                                     csr_write_en,
   input  logic [rtif_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [rtif_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);
   import rtif_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_CHECK, ST_TEST, ST_DIV_T, ST_DIV_U, ST_DIV_V, ST_DONE
   } state_type;

   state_type state_ff;

   logic signed [COORD_WIDTH-1:0] origin_ff [3];
   logic signed [COORD_WIDTH-1:0] dir_ff [3];
   logic [IDX_WIDTH-1:0]          hid_first_ff;
   logic [IDX_WIDTH-1:0]          hid_last_ff;

   logic signed [COORD_WIDTH-1:0] e1_ff [3];
   logic signed [COORD_WIDTH-1:0] e2_ff [3];
   logic signed [COORD_WIDTH-1:0] s_ff [3];
   logic signed [COORD_WIDTH-1:0] h_ff [3];
   logic signed [COORD_WIDTH-1:0] q_ff [3];
   logic signed [DOT_WIDTH-1:0]   dot_a_ff;
   logic signed [DOT_WIDTH-1:0]   dot_u_ff;
   logic signed [DOT_WIDTH-1:0]   dot_v_ff;
   logic signed [DOT_WIDTH-1:0]   dot_t_ff;
   logic [STEP_WIDTH-1:0]         step_ff;
   logic [TRI_WIDTH-1:0]          tri_ff;
   logic [QUO_WIDTH-1:0]          t_ff;
   logic [UV_WIDTH-1:0]           u_ff;

   logic signed [COORD_WIDTH-1:0] best_dist_ff;
   logic [UV_WIDTH-1:0]           best_u_ff;
   logic [UV_WIDTH-1:0]           best_v_ff;
   logic [TRI_WIDTH-1:0]          best_tri_ff;
   logic                          have_hit_ff;
   logic                          skip_ff;
   logic                          closer_ff;

   logic                          rsp_valid_ff;
   rsp_word_type                  rsp_word_ff;

   mac_ctrl_type                  mac_ctrl;
   mac_step_type                  cur_step;
   mac_step_type                  prev_step;
   logic signed [COORD_WIDTH-1:0] opnd_a;
   logic signed [COORD_WIDTH-1:0] opnd_b;
   logic signed [DOT_WIDTH-1:0]   acc_sum;
   div_ctrl_type                  div_ctrl;
   logic                          div_done;
   logic [QUO_WIDTH-1:0]          quotient;

   logic                          req_accept;
   logic [IDX_WIDTH-1:0]          vtx_lo;
   logic [IDX_WIDTH:0]            vtx_hi;
   logic                          skip_now;
   logic signed [DOT_WIDTH:0]     uv_sum;
   logic [DOT_WIDTH+TSAT_SHIFT-1:0] a_scaled;
   logic [DOT_WIDTH+TSAT_SHIFT-1:0] t_scaled;
   logic                          test_miss;
   logic                          t_ok;
   logic [DOT_WIDTH+FRACTION_BITS-1:0] num_t;
   logic [DOT_WIDTH+FRACTION_BITS-1:0] num_u;
   logic [DOT_WIDTH+FRACTION_BITS-1:0] num_v;

   function automatic logic signed [COORD_WIDTH-1:0] pick(input opnd_type sel);
      case (sel)
         OPND_E1X: return e1_ff[0];
         OPND_E1Y: return e1_ff[1];
         OPND_E1Z: return e1_ff[2];
         OPND_E2X: return e2_ff[0];
         OPND_E2Y: return e2_ff[1];
         OPND_E2Z: return e2_ff[2];
         OPND_SX:  return s_ff[0];
         OPND_SY:  return s_ff[1];
         OPND_SZ:  return s_ff[2];
         OPND_DX:  return dir_ff[0];
         OPND_DY:  return dir_ff[1];
         OPND_DZ:  return dir_ff[2];
         OPND_HX:  return h_ff[0];
         OPND_HY:  return h_ff[1];
         OPND_HZ:  return h_ff[2];
         OPND_QX:  return q_ff[0];
         OPND_QY:  return q_ff[1];
         OPND_QZ:  return q_ff[2];
         default:  return e1_ff[0];
      endcase
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   // Vertex indices 3p .. 3p+2 against the inclusive hidden range.
   assign vtx_lo = IDX_WIDTH'(req_word.triangle_index) + (IDX_WIDTH'(req_word.triangle_index) << 1);
   assign vtx_hi = (IDX_WIDTH+1)'(vtx_lo) + (IDX_WIDTH+1)'(2);
   assign skip_now = (hid_first_ff <= hid_last_ff)
                     && !((vtx_hi < (IDX_WIDTH+1)'(hid_first_ff)) || (vtx_lo > hid_last_ff));

   assign cur_step = mac_step(step_ff);
   assign prev_step = mac_step(step_ff - 1'b1);
   assign opnd_a = pick(cur_step.sel_a);
   assign opnd_b = pick(cur_step.sel_b);

   always_comb begin
      mac_ctrl.mul_en = (state_ff == ST_MAC) && (step_ff < STEP_WIDTH'(MAC_STEPS));
      mac_ctrl.acc_en = (state_ff == ST_MAC) && (step_ff != '0);
      mac_ctrl.op = prev_step.op;
   end

   rtif_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .opnd_a  (opnd_a),
      .opnd_b  (opnd_b),
      .acc_sum (acc_sum)
   );

   // All tests are exact on the full-width sums; a is non-negative here.
   assign uv_sum = (DOT_WIDTH+1)'(dot_u_ff) + (DOT_WIDTH+1)'(dot_v_ff);
   assign a_scaled = {dot_a_ff, {TSAT_SHIFT{1'b0}}};
   assign t_scaled = (DOT_WIDTH+TSAT_SHIFT)'(dot_t_ff);
   assign test_miss = dot_u_ff[DOT_WIDTH-1] || (dot_u_ff > dot_a_ff)
                      || dot_v_ff[DOT_WIDTH-1] || (uv_sum > (DOT_WIDTH+1)'(dot_a_ff))
                      || (dot_t_ff <= 0) || (t_scaled >= a_scaled);
   assign t_ok = (quotient != '0)
                 && ($signed({1'b0, quotient}) < best_dist_ff);

   assign num_t = {dot_t_ff, {FRACTION_BITS{1'b0}}};
   assign num_u = {dot_u_ff, {FRACTION_BITS{1'b0}}};
   assign num_v = {dot_v_ff, {FRACTION_BITS{1'b0}}};

   always_comb begin
      div_ctrl.start = 1'b0;
      div_ctrl.bits = QCNT_WIDTH'(UV_WIDTH);
      div_ctrl.rem_init = DOT_WIDTH'(num_u >> UV_WIDTH);
      div_ctrl.low_init = {num_u[UV_WIDTH-1:0], {(QUO_WIDTH-UV_WIDTH){1'b0}}};
      case (state_ff)
         ST_TEST: begin
            div_ctrl.start = !test_miss;
            div_ctrl.bits = QCNT_WIDTH'(QUO_WIDTH);
            div_ctrl.rem_init = DOT_WIDTH'(num_t >> QUO_WIDTH);
            div_ctrl.low_init = num_t[QUO_WIDTH-1:0];
         end
         ST_DIV_T: begin
            div_ctrl.start = div_done && t_ok;
         end
         ST_DIV_U: begin
            div_ctrl.start = div_done;
            div_ctrl.rem_init = DOT_WIDTH'(num_v >> UV_WIDTH);
            div_ctrl.low_init = {num_v[UV_WIDTH-1:0], {(QUO_WIDTH-UV_WIDTH){1'b0}}};
         end
         default: begin
            div_ctrl.start = 1'b0;
         end
      endcase
   end

   rtif_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .divisor  (dot_a_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= COORD_ONE;
         hid_first_ff <= '1;
         hid_last_ff <= '0;
         best_dist_ff <= COORD_MAX;
         best_u_ff <= '0;
         best_v_ff <= '0;
         best_tri_ff <= '0;
         have_hit_ff <= 1'b0;
         skip_ff <= 1'b0;
         closer_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ORIGIN_X:     origin_ff[0] <= csr_write_data;
               CSR_ORIGIN_Y:     origin_ff[1] <= csr_write_data;
               CSR_ORIGIN_Z:     origin_ff[2] <= csr_write_data;
               CSR_DIR_X:        dir_ff[0] <= csr_write_data;
               CSR_DIR_Y:        dir_ff[1] <= csr_write_data;
               CSR_DIR_Z:        dir_ff[2] <= csr_write_data;
               CSR_HIDDEN_FIRST: hid_first_ff <= csr_write_data[IDX_WIDTH-1:0];
               CSR_HIDDEN_LAST:  hid_last_ff <= csr_write_data[IDX_WIDTH-1:0];
               default:          hid_last_ff <= hid_last_ff;
            endcase
         end

         // In the done state the output register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  tri_ff <= req_word.triangle_index;
                  e1_ff[0] <= sat_diff(req_word.b_x, req_word.a_x);
                  e1_ff[1] <= sat_diff(req_word.b_y, req_word.a_y);
                  e1_ff[2] <= sat_diff(req_word.b_z, req_word.a_z);
                  e2_ff[0] <= sat_diff(req_word.c_x, req_word.a_x);
                  e2_ff[1] <= sat_diff(req_word.c_y, req_word.a_y);
                  e2_ff[2] <= sat_diff(req_word.c_z, req_word.a_z);
                  s_ff[0] <= sat_diff(origin_ff[0], req_word.a_x);
                  s_ff[1] <= sat_diff(origin_ff[1], req_word.a_y);
                  s_ff[2] <= sat_diff(origin_ff[2], req_word.a_z);
                  if (req_word.first_of_ray) begin
                     best_dist_ff <= COORD_MAX;
                     best_u_ff <= '0;
                     best_v_ff <= '0;
                     best_tri_ff <= '0;
                     have_hit_ff <= 1'b0;
                  end
                  skip_ff <= skip_now;
                  closer_ff <= 1'b0;
                  step_ff <= '0;
                  state_ff <= skip_now ? ST_DONE : ST_MAC;
               end
            end
            ST_MAC: begin
               if (step_ff != '0) begin
                  case (prev_step.dest)
                     DST_HX:    h_ff[0] <= sat_cross(acc_sum);
                     DST_HY:    h_ff[1] <= sat_cross(acc_sum);
                     DST_HZ:    h_ff[2] <= sat_cross(acc_sum);
                     DST_QX:    q_ff[0] <= sat_cross(acc_sum);
                     DST_QY:    q_ff[1] <= sat_cross(acc_sum);
                     DST_QZ:    q_ff[2] <= sat_cross(acc_sum);
                     DST_DOT_A: dot_a_ff <= acc_sum;
                     DST_DOT_U: dot_u_ff <= acc_sum;
                     DST_DOT_V: dot_v_ff <= acc_sum;
                     DST_DOT_T: dot_t_ff <= acc_sum;
                     default:   dot_t_ff <= dot_t_ff;
                  endcase
               end
               if (step_ff == STEP_WIDTH'(MAC_STEPS)) begin
                  state_ff <= ST_CHECK;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_CHECK: begin
               // A zero determinant means the ray runs parallel to the plane.
               if (dot_a_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  if (dot_a_ff[DOT_WIDTH-1]) begin
                     dot_a_ff <= -dot_a_ff;
                     dot_u_ff <= -dot_u_ff;
                     dot_v_ff <= -dot_v_ff;
                     dot_t_ff <= -dot_t_ff;
                  end
                  state_ff <= ST_TEST;
               end
            end
            ST_TEST: begin
               state_ff <= test_miss ? ST_DONE : ST_DIV_T;
            end
            ST_DIV_T: begin
               if (div_done) begin
                  t_ff <= quotient;
                  state_ff <= t_ok ? ST_DIV_U : ST_DONE;
               end
            end
            ST_DIV_U: begin
               if (div_done) begin
                  u_ff <= quotient[UV_WIDTH-1:0];
                  state_ff <= ST_DIV_V;
               end
            end
            ST_DIV_V: begin
               if (div_done) begin
                  best_dist_ff <= $signed({1'b0, t_ff});
                  best_u_ff <= u_ff;
                  best_v_ff <= quotient[UV_WIDTH-1:0];
                  best_tri_ff <= tri_ff;
                  have_hit_ff <= 1'b1;
                  closer_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff.skipped <= skip_ff;
                  rsp_word_ff.closer_hit <= closer_ff;
                  rsp_word_ff.any_hit <= have_hit_ff;
                  rsp_word_ff.best_distance <= best_dist_ff;
                  rsp_word_ff.best_u <= best_u_ff;
                  rsp_word_ff.best_v <= best_v_ff;
                  rsp_word_ff.best_triangle <= best_tri_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A new closest hit always leaves a stored hit behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_word.closer_hit || rsp_word.any_hit))
      else $error("closer hit reported without a stored hit");

   // A hidden triangle is never tested, so it cannot become the closest hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.skipped && rsp_word.closer_hit))
      else $error("skipped triangle reported as closer hit");

   // Without a stored hit the distance stays at its cleared value.
   assert property (@(posedge clock) disable iff (reset)
      !have_hit_ff |-> (best_dist_ff == COORD_MAX))
      else $error("distance changed without a hit");

   // The divider only runs while the sequencer waits on a quotient.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_T || state_ff == ST_DIV_U || state_ff == ST_DIV_V))
      else $error("divider finished outside a division state");

endmodule

// File: sv/rtif_mac.sv
module rtif_mac (
   input  logic                                 clock,
   input  rtif_pkg::mac_ctrl_type               ctrl,
   input  logic signed [rtif_pkg::COORD_WIDTH-1:0] opnd_a,
   input  logic signed [rtif_pkg::COORD_WIDTH-1:0] opnd_b,
   output logic signed [rtif_pkg::DOT_WIDTH-1:0]   acc_sum
);
   import rtif_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [DOT_WIDTH-1:0]  acc_ff;
   logic signed [DOT_WIDTH-1:0]  prod_ext;

   assign prod_ext = DOT_WIDTH'(prod_ff);

   always_comb begin
      case (ctrl.op)
         ACC_LOAD: acc_sum = prod_ext;
         ACC_ADD:  acc_sum = acc_ff + prod_ext;
         ACC_SUB:  acc_sum = acc_ff - prod_ext;
         default:  acc_sum = prod_ext;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= opnd_a * opnd_b;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_sum;
      end
   end

endmodule

// File: sv/rtif_div.sv
module rtif_div (
   input  logic                               clock,
   input  logic                               reset,
   input  rtif_pkg::div_ctrl_type             ctrl,
   input  logic [rtif_pkg::DOT_WIDTH-1:0]     divisor,
   output logic                               done,
   output logic [rtif_pkg::QUO_WIDTH-1:0]     quotient
);
   import rtif_pkg::*;

   logic                  busy_ff;
   logic [QCNT_WIDTH-1:0] cnt_ff;
   logic [DOT_WIDTH-1:0]  rem_ff;
   logic [QUO_WIDTH-1:0]  low_ff;
   logic [QUO_WIDTH-1:0]  quo_ff;
   logic [DOT_WIDTH-1:0]  trial;
   logic [DOT_WIDTH:0]    diff;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff[DOT_WIDTH-2:0], low_ff[QUO_WIDTH-1]};
   assign diff = {1'b0, trial} - {1'b0, divisor};
   assign done = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         cnt_ff <= ctrl.bits;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (ctrl.start) begin
         rem_ff <= ctrl.rem_init;
         low_ff <= ctrl.low_init;
         quo_ff <= '0;
      end else if (busy_ff && (cnt_ff != '0)) begin
         low_ff <= low_ff << 1;
         rem_ff <= diff[DOT_WIDTH] ? trial : diff[DOT_WIDTH-1:0];
         quo_ff <= {quo_ff[QUO_WIDTH-2:0], ~diff[DOT_WIDTH]};
      end
   end

endmodule
